// ===== hdl/hsvc_pkg.sv =====
// shared types and constants for the hsv color window classifier
package hsvc_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int HUE_W   = 15;
	localparam int SV_W    = 13;
	localparam int QBITS   = 13;
	localparam int NUM_W   = 22;
	localparam int DEN_W   = 8;
	localparam int HUE_FULL = 23040;
	localparam int ADDR_W  = 5;

	typedef enum logic [2:0] {
		REG_HUE_LOW_A  = 3'd0,
		REG_HUE_HIGH_A = 3'd1,
		REG_HUE_LOW_B  = 3'd2,
		REG_HUE_HIGH_B = 3'd3,
		REG_SAT_LOW    = 3'd4,
		REG_SAT_HIGH   = 3'd5,
		REG_VAL_LOW    = 3'd6,
		REG_VAL_HIGH   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [14:0] hue_low_a;
		logic [14:0] hue_high_a;
		logic [14:0] hue_low_b;
		logic [14:0] hue_high_b;
		logic [12:0] sat_low;
		logic [12:0] sat_high;
		logic [12:0] val_low;
		logic [12:0] val_high;
	} win_cfg_t;

	// one divider slot carried between cells
	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] hrem;
		logic [QBITS-1:0] hq;
		logic [NUM_W-1:0] srem;
		logic [QBITS-1:0] sq;
		logic [DEN_W-1:0] hden;
		logic [DEN_W-1:0] sden;
		logic             neg;
		logic             grey;
		logic [1:0]       sector;
		logic [12:0]      val;
		logic             in_map;
		logic [9:0]       row;
		logic [9:0]       col;
	} slot_t;

endpackage

// ===== hdl/hsvc_cell.sv =====
// one restoring division step for both hue and saturation quotients
module hsvc_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  hsvc_pkg::slot_t din,
	output hsvc_pkg::slot_t dout_q
);
	localparam int SH = hsvc_pkg::QBITS - 1 - STEP;

	logic [hsvc_pkg::NUM_W-1:0] htrial, strial;
	logic                       hge, sge;
	hsvc_pkg::slot_t            nxt;

	always_comb begin
		htrial = hsvc_pkg::NUM_W'(din.hden) << SH;
		strial = hsvc_pkg::NUM_W'(din.sden) << SH;
		hge = din.hrem >= htrial;
		sge = din.srem >= strial;
		nxt = din;
		nxt.hrem = hge ? din.hrem - htrial : din.hrem;
		nxt.srem = sge ? din.srem - strial : din.srem;
		nxt.hq[SH] = hge;
		nxt.sq[SH] = sge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_q <= '0;
		end else if (advance) begin
			dout_q <= nxt;
		end
	end
endmodule

// ===== hdl/hsvc_regs.sv =====
// apb register file holding the hue, saturation and value windows
module hsvc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hsvc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output hsvc_pkg::win_cfg_t           cfg_q
);
	logic               wr;
	hsvc_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr  = psel && penable && pwrite;
	assign idx = hsvc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low_a  <= 15'd0;
			cfg_q.hue_high_a <= 15'd1280;
			cfg_q.hue_low_b  <= 15'd21760;
			cfg_q.hue_high_b <= 15'd23039;
			cfg_q.sat_low    <= 13'd1920;
			cfg_q.sat_high   <= 13'd6400;
			cfg_q.val_low    <= 13'd1280;
			cfg_q.val_high   <= 13'd6400;
		end else if (wr) begin
			unique case (idx)
				hsvc_pkg::REG_HUE_LOW_A:  cfg_q.hue_low_a  <= pwdata[14:0];
				hsvc_pkg::REG_HUE_HIGH_A: cfg_q.hue_high_a <= pwdata[14:0];
				hsvc_pkg::REG_HUE_LOW_B:  cfg_q.hue_low_b  <= pwdata[14:0];
				hsvc_pkg::REG_HUE_HIGH_B: cfg_q.hue_high_b <= pwdata[14:0];
				hsvc_pkg::REG_SAT_LOW:    cfg_q.sat_low    <= pwdata[12:0];
				hsvc_pkg::REG_SAT_HIGH:   cfg_q.sat_high   <= pwdata[12:0];
				hsvc_pkg::REG_VAL_LOW:    cfg_q.val_low    <= pwdata[12:0];
				hsvc_pkg::REG_VAL_HIGH:   cfg_q.val_high   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			hsvc_pkg::REG_HUE_LOW_A:  prdata = {17'd0, cfg_q.hue_low_a};
			hsvc_pkg::REG_HUE_HIGH_A: prdata = {17'd0, cfg_q.hue_high_a};
			hsvc_pkg::REG_HUE_LOW_B:  prdata = {17'd0, cfg_q.hue_low_b};
			hsvc_pkg::REG_HUE_HIGH_B: prdata = {17'd0, cfg_q.hue_high_b};
			hsvc_pkg::REG_SAT_LOW:    prdata = {19'd0, cfg_q.sat_low};
			hsvc_pkg::REG_SAT_HIGH:   prdata = {19'd0, cfg_q.sat_high};
			hsvc_pkg::REG_VAL_LOW:    prdata = {19'd0, cfg_q.val_low};
			hsvc_pkg::REG_VAL_HIGH:   prdata = {19'd0, cfg_q.val_high};
			default: prdata = 32'd0;
		endcase
		if (paddr[1:0] != 2'b00) prdata = 32'd0;
	end
endmodule

// ===== hdl/hsv_color_window_classifier_unit.sv =====
// top level of the hsv color window classifier
// Accepts one pixel request per clock unless the output stalls, and returns
// one result per request through one register after min/max and numerators, a
// chain of 13 division cells (one quotient bit each, hue and saturation side by
// side), and the output register, which also takes the sign fix-up and window
// compares. The whole chain advances together; stall on the output holds it.
// Window registers sit behind an APB port at byte addresses 4*i and should be
// written while idle.
module hsv_color_window_classifier_unit #(
	parameter int MAX_WIDTH  = hsvc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = hsvc_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [9:0]  column,
	input  logic [9:0]  row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_target,
	output logic [14:0] hue,
	output logic [12:0] saturation,
	output logic [12:0] brightness,
	output logic [9:0]  mask_row,
	output logic [6:0]  mask_byte,
	output logic [7:0]  mask_bit
);
	localparam int N = hsvc_pkg::QBITS;

	hsvc_pkg::win_cfg_t cfg;
	hsvc_pkg::slot_t    chain [0:N];
	hsvc_pkg::slot_t    head;
	logic               advance;

	hsvc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg_q(cfg)
	);

	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	logic [7:0]  mx, mn, d, pa, pb;
	logic        nega;
	logic [1:0]  sec;
	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) mx = blue;
		mn = (red < green) ? red : green;
		if (blue < mn) mn = blue;
		d = mx - mn;
		if (mx == red) begin
			pa = green; pb = blue; sec = 2'd0;
		end else if (mx == green) begin
			pa = blue; pb = red; sec = 2'd1;
		end else begin
			pa = red; pb = green; sec = 2'd2;
		end
		nega = pa < pb;
		head.valid  = in_valid;
		head.hrem   = hsvc_pkg::NUM_W'((nega ? (pb - pa) : (pa - pb))) * 22'd3840;
		head.hq     = '0;
		head.srem   = hsvc_pkg::NUM_W'(d) * 22'd6400;
		head.sq     = '0;
		// grey pixels divide zero by one
		head.hden   = (d == 8'd0) ? 8'd1 : d;
		head.sden   = (d == 8'd0) ? 8'd1 : mx;
		head.neg    = nega;
		head.grey   = (d == 8'd0);
		head.sector = sec;
		head.val    = 13'(mx) * 13'd25;
		head.in_map = (32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
		head.row    = row;
		head.col    = column;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (advance) begin
			chain[0] <= head;
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			hsvc_cell #(.STEP(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .advance(advance),
				.din(chain[k]), .dout_q(chain[k+1])
			);
		end
	endgenerate

	hsvc_pkg::slot_t t;
	logic [15:0] base, hv;
	logic [14:0] h;
	logic        hit;
	always_comb begin
		t = chain[N];
		unique case (t.sector)
			2'd1:    base = 16'd7680;
			2'd2:    base = 16'd15360;
			default: base = 16'd0;
		endcase
		if (t.neg) begin
			hv = base - 16'(t.hq) - ((t.hrem != '0) ? 16'd1 : 16'd0);
			if (hv[15]) hv = hv + 16'(hsvc_pkg::HUE_FULL);
		end else begin
			hv = base + 16'(t.hq);
		end
		h = t.grey ? 15'd0 : hv[14:0];
		hit = ((h >= cfg.hue_low_a && h <= cfg.hue_high_a) ||
		       (h >= cfg.hue_low_b && h <= cfg.hue_high_b)) &&
		      (t.sq >= cfg.sat_low && t.sq <= cfg.sat_high) &&
		      (t.val >= cfg.val_low && t.val <= cfg.val_high) && t.in_map;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= t.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_target  <= hit;
			hue        <= h;
			saturation <= t.grey ? 13'd0 : t.sq;
			brightness <= t.val;
			mask_row   <= t.row;
			mask_byte  <= t.col[9:3];
			mask_bit   <= 8'h80 >> t.col[2:0];
		end
	end
endmodule
